// ===== design/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes for the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_ALLOC3 = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_DEC,
    S_SHL_RD,
    S_SHL_EV,
    S_SHR_RD,
    S_SHR_EV,
    S_OUT
  } state_e;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_LOST    = 3'd2;
  localparam logic [2:0] ST_OVERLAP = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;

endpackage

`default_nettype wire

// ===== design/first_fit_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// Address-sorted free segment table with first-fit allocation, merging free
// and an all-or-nothing triple allocation, run by a sequencer over one RAM.
// ----------------------------------------------------------------------------
// Each table entry scanned is read, then evaluated; an insert or remove also
// shifts the entries behind it, each read then written. Triple allocation
// scans the table to check and, only when all three fit, again to commit.
// One operation at a time: a new transfer is taken only when all results of
// the previous one have gone. Reset empties the table at once (no sweep).
`default_nettype none

module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int SEGMENTS  = 64,
  parameter int ADDR_BITS = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  // Fields from bit 0: mode, addr, size, size_b, size_c, zero padding.
  input  wire logic [((2+4*ADDR_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic      m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // Fields from bit 0: result_addr, status, zero padding.
  output logic      [((ADDR_BITS+3+7)/8)*8-1:0] m_axis_tdata_o,
  output logic      m_axis_tlast_o
);

  localparam int AW = ADDR_BITS;
  localparam int CW = $clog2(SEGMENTS + 1);
  localparam int XW = $clog2(SEGMENTS);
  localparam int EW = 2 * AW;
  localparam int OW = ((AW + 3 + 7) / 8) * 8;
  localparam logic [CW-1:0] FULL = CW'(SEGMENTS);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   pass_q, pass_d;
  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] sz_q [3];
  logic [AW-1:0] sz_d [3];
  logic [CW-1:0] idx_q, idx_d, j_q, j_d, w_q, w_d, cnt_q, cnt_d;
  logic [AW-1:0] lb_q, lb_d, ll_q, ll_d, rb_q, rb_d, rl_q, rl_d;
  logic          hl_q, hl_d, hr_q, hr_d;
  logic [2:0]    placed_q, placed_d;
  logic [AW-1:0] got_q [3];
  logic [AW-1:0] got_d [3];
  logic [2:0]    st_q, st_d;
  logic [1:0]    k_q, k_d;

  logic          we;
  logic [XW-1:0] waddr, raddr;
  logic [AW-1:0] wb, wl;
  logic [EW-1:0] rdata;
  logic [AW-1:0] e_base, e_len;

  logic [1:0]    in_mode;
  logic [AW-1:0] in_addr, in_size, in_size_b, in_size_c;
  logic [AW:0]   in_end, f_end, l_end;
  logic          in_bad, ovl, jl, jr, scan_end, hit, last_k;

  logic [AW-1:0] cb, cl;
  logic [AW-1:0] cg [3];
  logic [2:0]    pl;

  ffsa_ram #(.WIDTH(EW), .DEPTH(SEGMENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({wb, wl}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign e_base = rdata[EW-1:AW];
  assign e_len  = rdata[AW-1:0];

  assign in_mode   = s_axis_tdata_i[1:0];
  assign in_addr   = s_axis_tdata_i[2+AW-1:2];
  assign in_size   = s_axis_tdata_i[2+2*AW-1:2+AW];
  assign in_size_b = s_axis_tdata_i[2+3*AW-1:2+2*AW];
  assign in_size_c = s_axis_tdata_i[2+4*AW-1:2+3*AW];

  // A span may end exactly at the top of the address space but not beyond.
  assign in_end = {1'b0, in_addr} + {1'b0, in_size};
  assign in_bad = (in_addr == '0) || (in_end[AW] && (in_end[AW-1:0] != '0));

  assign f_end = {1'b0, a_q} + {1'b0, sz_q[0]};
  assign l_end = {1'b0, lb_q} + {1'b0, ll_q};
  assign ovl   = (hl_q && (l_end > {1'b0, a_q})) || (hr_q && (f_end > {1'b0, rb_q}));
  assign jl    = hl_q && (l_end == {1'b0, a_q});
  assign jr    = hr_q && (f_end == {1'b0, rb_q});

  assign scan_end = (idx_q == cnt_q);
  assign hit      = (e_len >= sz_q[0]);
  assign last_k   = (op_q == OP_ALLOC3) ? (k_q == 2'd2) : (k_q == 2'd0);

  // Places the outstanding requests of a triple allocation into one entry.
  always_comb begin
    cb = e_base;
    cl = e_len;
    pl = placed_q;
    for (int n = 0; n < 3; n++) begin
      cg[n] = cb;
      if (!pl[n] && (sz_q[n] <= cl)) begin
        pl[n] = 1'b1;
        cb    = cb + sz_q[n];
        cl    = cl - sz_q[n];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          unique case (op_e'(in_mode))
            OP_INIT:   state_d = S_OUT;
            OP_ALLOC:  state_d = (in_size == '0) ? S_OUT : S_RD;
            OP_FREE:   state_d = ((in_size == '0) || in_bad) ? S_OUT : S_RD;
            OP_ALLOC3: state_d = S_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (scan_end) begin
          state_d = (op_q == OP_FREE) ? S_DEC : S_OUT;
        end else begin
          state_d = S_EV;
        end
      end
      S_EV: begin
        unique case (op_q)
          OP_ALLOC: begin
            if (hit) begin
              state_d = (e_len == sz_q[0]) ? S_SHL_RD : S_OUT;
            end else begin
              state_d = S_RD;
            end
          end
          OP_FREE:  state_d = (e_base <= a_q) ? S_RD : S_DEC;
          default:  state_d = S_RD;
        endcase
      end
      S_DEC: begin
        if (ovl) begin
          state_d = S_OUT;
        end else if (jl && jr) begin
          state_d = S_SHL_RD;
        end else if (jl || jr || (cnt_q == FULL)) begin
          state_d = S_OUT;
        end else begin
          state_d = S_SHR_RD;
        end
      end
      S_SHL_RD: state_d = (CW'(j_q + 1'b1) >= cnt_q) ? S_OUT : S_SHL_EV;
      S_SHL_EV: state_d = S_SHL_RD;
      S_SHR_RD: state_d = (j_q == idx_q) ? S_OUT : S_SHR_EV;
      S_SHR_EV: state_d = S_SHR_RD;
      S_OUT: begin
        if (m_axis_tready_i && last_k) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d     = op_q;
    pass_d   = pass_q;
    a_d      = a_q;
    sz_d     = sz_q;
    idx_d    = idx_q;
    j_d      = j_q;
    w_d      = w_q;
    cnt_d    = cnt_q;
    lb_d     = lb_q;
    ll_d     = ll_q;
    rb_d     = rb_q;
    rl_d     = rl_q;
    hl_d     = hl_q;
    hr_d     = hr_q;
    placed_d = placed_q;
    got_d    = got_q;
    st_d     = st_q;
    k_d      = k_q;
    we       = 1'b0;
    waddr    = idx_q[XW-1:0];
    wb       = a_q;
    wl       = sz_q[0];
    raddr    = idx_q[XW-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = op_e'(in_mode);
          pass_d   = 1'b0;
          a_d      = in_addr;
          sz_d[0]  = in_size;
          sz_d[1]  = in_size_b;
          sz_d[2]  = in_size_c;
          idx_d    = '0;
          hl_d     = 1'b0;
          hr_d     = 1'b0;
          placed_d = '0;
          got_d[0] = '0;
          got_d[1] = '0;
          got_d[2] = '0;
          st_d     = ST_OK;
          k_d      = '0;
          case (op_e'(in_mode))
            OP_INIT: begin
              if (in_bad) begin
                st_d = ST_BAD;
              end else begin
                cnt_d = (in_size != '0) ? CW'(1) : '0;
                we    = 1'b1;
                waddr = '0;
                wb    = in_addr;
                wl    = in_size;
              end
            end
            OP_ALLOC: begin
              if (in_size == '0) begin
                st_d = ST_BAD;
              end
            end
            OP_FREE: begin
              if ((in_size != '0) && in_bad) begin
                st_d = ST_BAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (scan_end) begin
          if (op_q == OP_ALLOC) begin
            st_d = ST_NOFIT;
          end else if (op_q == OP_ALLOC3) begin
            if (pass_q) begin
              cnt_d = w_q;
            end else begin
              st_d = ST_NOFIT;
            end
          end
        end
      end
      S_EV: begin
        case (op_q)
          OP_ALLOC: begin
            if (hit) begin
              got_d[0] = e_base;
              if (e_len == sz_q[0]) begin
                j_d = idx_q;
              end else begin
                we = 1'b1;
                wb = e_base + sz_q[0];
                wl = e_len - sz_q[0];
              end
            end else begin
              idx_d = CW'(idx_q + 1'b1);
            end
          end
          OP_FREE: begin
            if (e_base <= a_q) begin
              lb_d  = e_base;
              ll_d  = e_len;
              hl_d  = 1'b1;
              idx_d = CW'(idx_q + 1'b1);
            end else begin
              rb_d = e_base;
              rl_d = e_len;
              hr_d = 1'b1;
            end
          end
          default: begin
            idx_d    = CW'(idx_q + 1'b1);
            placed_d = pl;
            if (!pass_q) begin
              // All three fit: rescan from the start and commit.
              if (&pl) begin
                pass_d   = 1'b1;
                idx_d    = '0;
                w_d      = '0;
                placed_d = '0;
              end
            end else begin
              for (int n = 0; n < 3; n++) begin
                if (pl[n] && !placed_q[n]) begin
                  got_d[n] = cg[n];
                end
              end
              if (cl != '0) begin
                we    = 1'b1;
                waddr = w_q[XW-1:0];
                wb    = cb;
                wl    = cl;
                w_d   = CW'(w_q + 1'b1);
              end
            end
          end
        endcase
      end
      S_DEC: begin
        if (ovl) begin
          st_d = ST_OVERLAP;
        end else if (jl) begin
          we    = 1'b1;
          waddr = XW'(idx_q - 1'b1);
          wb    = lb_q;
          wl    = jr ? (ll_q + sz_q[0] + rl_q) : (ll_q + sz_q[0]);
          j_d   = idx_q;
        end else if (jr) begin
          we = 1'b1;
          wb = a_q;
          wl = rl_q + sz_q[0];
        end else if (cnt_q == FULL) begin
          st_d = ST_LOST;
        end else begin
          j_d = cnt_q;
        end
      end
      S_SHL_RD: begin
        raddr = XW'(j_q + 1'b1);
        if (CW'(j_q + 1'b1) >= cnt_q) begin
          cnt_d = CW'(cnt_q - 1'b1);
        end
      end
      S_SHL_EV: begin
        we    = 1'b1;
        waddr = j_q[XW-1:0];
        wb    = e_base;
        wl    = e_len;
        j_d   = CW'(j_q + 1'b1);
      end
      S_SHR_RD: begin
        raddr = XW'(j_q - 1'b1);
        if (j_q == idx_q) begin
          we    = 1'b1;
          cnt_d = CW'(cnt_q + 1'b1);
        end
      end
      S_SHR_EV: begin
        we    = 1'b1;
        waddr = j_q[XW-1:0];
        wb    = e_base;
        wl    = e_len;
        j_d   = CW'(j_q - 1'b1);
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          k_d = k_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pass_q   <= pass_d;
    a_q      <= a_d;
    sz_q     <= sz_d;
    idx_q    <= idx_d;
    j_q      <= j_d;
    w_q      <= w_d;
    lb_q     <= lb_d;
    ll_q     <= ll_d;
    rb_q     <= rb_d;
    rl_q     <= rl_d;
    hl_q     <= hl_d;
    hr_q     <= hr_d;
    placed_q <= placed_d;
    got_q    <= got_d;
    st_q     <= st_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tlast_o  = last_k;
  assign m_axis_tdata_o  = OW'({st_q, (k_q == 2'd0) ? got_q[0] :
                                      (k_q == 2'd1) ? got_q[1] : got_q[2]});

endmodule

`default_nettype wire

// ===== design/ffsa_ram.sv =====
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== tb/sv/first_fit_segment_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_checker
// Watches both streams, predicts every result of the segment allocator from
// its own copy of the free table and compares each result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator_checker
  import ffsa_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_ready_i,
  input  wire logic [103:0] in_data_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_ready_i,
  input  wire logic [31:0]  out_data_i,
  input  wire logic         out_last_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = 64;
  localparam logic [24:0] SPACE = 25'h1000000;

  typedef struct packed {
    logic [23:0] addr;
    logic [2:0]  status;
    logic        last;
  } alloc_result_t;

  logic [23:0] base_q [NSEG];
  logic [23:0] len_q  [NSEG];
  int          count_q;
  alloc_result_t due_q [$];

  assign pending_o = due_q.size();

  function automatic void drop_seg(int i);
    for (int k = i; k < count_q - 1; k++) begin
      base_q[k] = base_q[k+1];
      len_q[k]  = len_q[k+1];
    end
    count_q--;
  endfunction

  function automatic logic [2:0] table_init(logic [23:0] a, logic [23:0] s);
    if (a == 0 || {1'b0, a} + {1'b0, s} > SPACE) return ST_BAD;
    count_q = 0;
    if (s != 0) begin
      base_q[0] = a;
      len_q[0]  = s;
      count_q   = 1;
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] table_alloc(logic [23:0] s, output logic [23:0] got);
    got = 0;
    if (s == 0) return ST_BAD;
    for (int i = 0; i < count_q; i++) begin
      if (len_q[i] >= s) begin
        got = base_q[i];
        len_q[i] -= s;
        if (len_q[i] == 0) drop_seg(i);
        else base_q[i] += s;
        return ST_OK;
      end
    end
    return ST_NOFIT;
  endfunction

  function automatic logic [2:0] table_free(logic [23:0] a, logic [23:0] s);
    int i;
    logic [24:0] fin, lend;
    bit hl, hr, jl, jr;
    i = 0;
    if (s == 0) return ST_OK;
    if (a == 0 || {1'b0, a} + {1'b0, s} > SPACE) return ST_BAD;
    fin = {1'b0, a} + {1'b0, s};
    while (i < count_q && base_q[i] <= a) i++;
    hl = i > 0;
    hr = i < count_q;
    lend = hl ? {1'b0, base_q[i-1]} + {1'b0, len_q[i-1]} : 25'd0;
    if (hl && lend > {1'b0, a}) return ST_OVERLAP;
    if (hr && fin > {1'b0, base_q[i]}) return ST_OVERLAP;
    jl = hl && lend == {1'b0, a};
    jr = hr && fin == {1'b0, base_q[i]};
    if (jl) begin
      len_q[i-1] += s;
      if (jr) begin
        len_q[i-1] += len_q[i];
        drop_seg(i);
      end
      return ST_OK;
    end
    if (jr) begin
      base_q[i] = a;
      len_q[i] += s;
      return ST_OK;
    end
    if (count_q >= NSEG) return ST_LOST;
    for (int k = count_q; k > i; k--) begin
      base_q[k] = base_q[k-1];
      len_q[k]  = len_q[k-1];
    end
    base_q[i] = a;
    len_q[i]  = s;
    count_q++;
    return ST_OK;
  endfunction

  // All three requests are placed on a scratch copy; the table changes only
  // when every one of them fits.
  function automatic bit table_alloc3(logic [23:0] sz [3], output logic [23:0] got [3]);
    logic [23:0] spare [NSEG];
    int  slot [3];
    bit  done [3];
    int  found, w;
    found = 0;
    for (int n = 0; n < 3; n++) begin
      done[n] = 0;
      slot[n] = 0;
      got[n]  = 0;
    end
    spare = len_q;
    for (int i = 0; i < count_q && found < 3; i++)
      for (int n = 0; n < 3; n++)
        if (!done[n] && sz[n] <= spare[i]) begin
          done[n] = 1;
          slot[n] = i;
          spare[i] -= sz[n];
          found++;
        end
    if (found < 3) return 0;
    len_q = spare;
    for (int n = 0; n < 3; n++) begin
      got[n] = base_q[slot[n]];
      base_q[slot[n]] += sz[n];
    end
    w = 0;
    for (int i = 0; i < count_q; i++)
      if (len_q[i] != 0) begin
        base_q[w] = base_q[i];
        len_q[w]  = len_q[i];
        w++;
      end
    count_q = w;
    return 1;
  endfunction

  task automatic predict_request(logic [103:0] d);
    op_e         op;
    logic [23:0] a, s, got;
    logic [23:0] sz [3];
    logic [23:0] g3 [3];
    logic [2:0]  st;
    bit          ok;
    op    = op_e'(d[1:0]);
    a     = d[25:2];
    s     = d[49:26];
    sz[0] = s;
    sz[1] = d[73:50];
    sz[2] = d[97:74];
    case (op)
      OP_INIT: due_q.push_back('{24'd0, table_init(a, s), 1'b1});
      OP_ALLOC: begin
        st = table_alloc(s, got);
        due_q.push_back('{got, st, 1'b1});
      end
      OP_FREE: due_q.push_back('{24'd0, table_free(a, s), 1'b1});
      default: begin
        ok = table_alloc3(sz, g3);
        for (int k = 0; k < 3; k++)
          due_q.push_back('{ok ? g3[k] : 24'd0, ok ? ST_OK : ST_NOFIT, k == 2});
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      count_q      = 0;
      fail_count_o = 0;
      due_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) predict_request(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual addr %h status %0d last %b",
                   $time, out_data_i[23:0], out_data_i[26:24], out_last_i);
          fail_count_o++;
        end else begin
          want = due_q.pop_front();
          if (want.addr !== out_data_i[23:0] || want.status !== out_data_i[26:24] ||
              want.last !== out_last_i || out_data_i[31:27] !== 5'd0) begin
            $display("%0t: expected addr %h status %0d last %b, actual addr %h status %0d last %b",
                     $time, want.addr, want.status, want.last,
                     out_data_i[23:0], out_data_i[26:24], out_last_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/first_fit_segment_allocator_test.sv =====
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_test
// Drives directed and random init, allocate, free and triple-allocate
// requests into the allocator with random gaps on both streams; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator_test;
  import ffsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [31:0]  m_axis_tdata_o;
  logic         m_axis_tlast_o;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  int           stall = 0;
  bit           sending = 1;
  logic [23:0]  handed [$];

  first_fit_segment_allocator i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
  );

  first_fit_segment_allocator_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_i(s_axis_tready_o), .in_data_i(s_axis_tdata_i),
    .out_valid_i(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_data_i(m_axis_tdata_o), .out_last_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Mostly small sizes so that the table fills and splits.
  function automatic logic [23:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 24'd0;
    if (r < 80) return 24'($urandom_range(1, 64));
    if (r < 95) return 24'($urandom_range(65, 4096));
    return 24'($urandom());
  endfunction

  task automatic send(op_e op, logic [23:0] a, logic [23:0] s,
                      logic [23:0] sb = 0, logic [23:0] sc = 0);
    repeat (gap_len()) @(negedge clk_i);
    s_axis_tdata_i  = {6'd0, sc, sb, s, a, op};
    s_axis_tvalid_i = 1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    s_axis_tvalid_i = 0;
  endtask

  // Short random back-pressure, with an occasional long stall.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 0;
    end else if (stall > 0) begin
      m_axis_tready_i <= 0;
      stall <= stall - 1;
    end else if ($urandom_range(0, 39) == 0) begin
      m_axis_tready_i <= 0;
      stall <= $urandom_range(10, 60);
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready_i <= 0;
    end else begin
      m_axis_tready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else if (sending || pending != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [23:0] a, s;
    int r;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // Directed part: empty table, bad requests, extremes, merges and alloc3.
    send(OP_ALLOC3, 0, 0, 0, 0);
    send(OP_ALLOC, 0, 1);
    send(OP_INIT, 0, 10);
    send(OP_INIT, 24'hFFFFFF, 2);
    send(OP_INIT, 24'hFFFFFF, 1);
    send(OP_ALLOC, 0, 24'hFFFFFF);
    send(OP_ALLOC, 0, 1);
    send(OP_INIT, 5, 0);
    send(OP_INIT, 1, 24'hFFFFFF);
    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 0, 24'hFFFFFF);
    send(OP_INIT, 100, 1000);
    send(OP_ALLOC, 0, 2000);
    send(OP_ALLOC, 0, 100);
    send(OP_FREE, 50, 0);
    send(OP_FREE, 0, 5);
    send(OP_FREE, 24'hFFFFFF, 2);
    send(OP_FREE, 150, 10);
    send(OP_FREE, 120, 10);
    send(OP_FREE, 130, 10);
    send(OP_FREE, 100, 20);
    send(OP_FREE, 2000, 24'(24'hFFFFFF - 2000 + 1));
    send(OP_ALLOC3, 30, 0, 24'hFFFFFF);
    send(OP_ALLOC3, 30, 0, 40);
    send(OP_ALLOC3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    // Fill the table with isolated spans until it is full and spans are lost.
    send(OP_INIT, 1, 1);
    for (int k = 0; k < 64; k++) send(OP_FREE, 24'(10 + k * 4), 2);
    send(OP_FREE, 24'd2, 1);
    // Random part: mostly allocate and free, freeing random spans in and near the allocated area.
    send(OP_INIT, 24'h000100, 24'h00F000);
    for (int n = 0; n < 20; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        a = $urandom_range(0, 3) == 0 ? 24'd0 : 24'($urandom_range(1, 4096));
        send(OP_INIT, a, $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'h8000);
        handed.delete();
      end else if (r < 35) begin
        s = rand_size();
        send(OP_ALLOC, 0, s);
        handed.push_back(s);
      end else if (r < 75) begin
        // Free pieces of the allocated area, sometimes overlapping or odd.
        a = $urandom_range(0, 9) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 24'h10000));
        send(OP_FREE, a, rand_size());
      end else begin
        send(OP_ALLOC3, 24'($urandom()), rand_size(), rand_size(), rand_size());
      end
    end
    sending = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/ffsa_pkg.sv
design/ffsa_ram.sv
design/first_fit_segment_allocator.sv
tb/sv/first_fit_segment_allocator_checker.sv
tb/sv/first_fit_segment_allocator_test.sv
